/* rtl/core/btmx_pkg.sv */
`timescale 1ns / 1ps

package btmx_pkg;

   localparam int KEY_BITS = 31;
   localparam int KIW      = $clog2(KEY_BITS);
   localparam int REM_W    = $clog2(KEY_BITS + 1);
   localparam int COUNT_W  = 14;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam int DEF_NODE_POOL = 8192;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [KEY_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] xor_result;
      logic [1:0]          status;
   } rsp_type;

endpackage

/* rtl/core/binary_trie_max_xor_top.sv */
`timescale 1ns / 1ps

// channel   ports                           direction  payload
// request   req_valid req_ready req_data    in         opcode, key
// response  rsp_valid rsp_ready rsp_data    out        xor_result, status
//
// One request at a time; every trie level is a fetch and then a use of the
// single node memory (registered read). Insert and delete walk the key path
// twice, first to scan it and then to update it.
// Reset needs no clearing pass: nodes are handed out in order from a fill
// count and a new node is written whole on the walk that allocates it.
// A finished response waits in rsp_data while the next request is taken.
module binary_trie_max_xor_top
   import btmx_pkg::*;
#(
   parameter int NODE_POOL = DEF_NODE_POOL
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int NW  = $clog2(NODE_POOL);
   localparam int NFW = $clog2(NODE_POOL + 1);
   localparam logic [NW-1:0] NULL_NODE = '0;
   localparam logic [NW-1:0] ROOT_NODE = NW'(1);

   typedef struct packed {
      logic [NW-1:0]      zero_child;
      logic [NW-1:0]      one_child;
      logic [COUNT_W-1:0] count;
   } node_word_type;

   typedef enum logic [14:0] {
      IDLE    = 15'b000000000000001,
      I1_WAIT = 15'b000000000000010,
      I1_SCAN = 15'b000000000000100,
      I_CHECK = 15'b000000000001000,
      I2_WAIT = 15'b000000000010000,
      I2_UPD  = 15'b000000000100000,
      D1_WAIT = 15'b000000001000000,
      D1_SCAN = 15'b000000010000000,
      D2_WAIT = 15'b000000100000000,
      D2_UPD  = 15'b000001000000000,
      Q_WAIT  = 15'b000010000000000,
      Q_NODE  = 15'b000100000000000,
      Q_OWAIT = 15'b001000000000000,
      Q_OPP   = 15'b010000000000000,
      DONE    = 15'b100000000000000
   } state_type;

   state_type               state_ff, state_in;
   logic [NW-1:0]           node_ff, node_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic                    fresh_ff, fresh_in;
   logic [REM_W-1:0]        missing_ff, missing_in;
   logic [NW-1:0]           same_ff, same_in;
   logic [KEY_BITS-1:0]     res_ff, res_in;
   logic [1:0]              status_ff, status_in;
   logic [KEY_BITS-1:0]     key_ff;
   node_word_type           root_ff, root_in;
   logic [NFW-1:0]          next_free_ff, next_free_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   node_word_type           rd_data_ff;
   node_word_type           node_mem [NODE_POOL];

   node_word_type           cur_word;
   node_word_type           wr_word;
   logic                    word_wr;
   logic                    mem_we;
   logic [KIW-1:0]          bit_idx;
   logic                    kbit;
   logic [NW-1:0]           cur_child;
   logic [NW-1:0]           cur_opp;
   logic [NW-1:0]           next_node;
   logic                    alloc;
   logic [NFW:0]            pool_need;

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cur_word  = (node_ff == NULL_NODE || fresh_ff) ? '0 :
                      (node_ff == ROOT_NODE) ? root_ff : rd_data_ff;
   assign bit_idx   = KIW'(rem_ff - REM_W'(1));
   assign kbit      = key_ff[bit_idx];
   assign cur_child = kbit ? cur_word.one_child : cur_word.zero_child;
   assign cur_opp   = kbit ? cur_word.zero_child : cur_word.one_child;
   assign alloc     = (cur_child == NULL_NODE);
   assign next_node = alloc ? next_free_ff[NW-1:0] : cur_child;
   assign pool_need = (NFW+1)'(next_free_ff) + (NFW+1)'(missing_ff);

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      rem_in       = rem_ff;
      fresh_in     = fresh_ff;
      missing_in   = missing_ff;
      same_in      = same_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      root_in      = root_ff;
      next_free_in = next_free_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_word      = cur_word;
      word_wr      = 1'b0;
      mem_we       = 1'b0;

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               node_in   = ROOT_NODE;
               rem_in    = REM_W'(KEY_BITS);
               fresh_in  = 1'b0;
               res_in    = '0;
               status_in = ST_OK;
               unique case (req_data.opcode)
                  OP_INSERT: begin
                     if (root_ff.count == COUNT_MAX) begin
                        status_in = ST_FULL;
                        state_in  = DONE;
                     end else begin
                        state_in = I1_WAIT;
                     end
                  end
                  OP_DELETE: state_in = D1_WAIT;
                  OP_QUERY: begin
                     if (root_ff.count == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = DONE;
                     end else begin
                        state_in = Q_WAIT;
                     end
                  end
                  default: state_in = DONE;
               endcase
            end
         end
         I1_WAIT: state_in = I1_SCAN;
         I1_SCAN: begin
            if (rem_ff == '0) begin
               missing_in = '0;
               state_in   = I_CHECK;
            end else if (alloc) begin
               missing_in = rem_ff;
               state_in   = I_CHECK;
            end else begin
               node_in  = cur_child;
               rem_in   = rem_ff - REM_W'(1);
               state_in = I1_WAIT;
            end
         end
         I_CHECK: begin
            if (pool_need > (NFW+1)'(NODE_POOL)) begin
               status_in = ST_FULL;
               state_in  = DONE;
            end else begin
               node_in  = ROOT_NODE;
               rem_in   = REM_W'(KEY_BITS);
               fresh_in = 1'b0;
               state_in = I2_WAIT;
            end
         end
         I2_WAIT: state_in = I2_UPD;
         I2_UPD: begin
            word_wr       = 1'b1;
            wr_word.count = cur_word.count + COUNT_W'(1);
            if (rem_ff == '0) begin
               state_in = DONE;
            end else begin
               if (alloc) begin
                  next_free_in = next_free_ff + NFW'(1);
                  fresh_in     = 1'b1;
               end
               if (kbit) begin
                  wr_word.one_child = next_node;
               end else begin
                  wr_word.zero_child = next_node;
               end
               node_in  = next_node;
               rem_in   = rem_ff - REM_W'(1);
               state_in = I2_WAIT;
            end
         end
         D1_WAIT: state_in = D1_SCAN;
         D1_SCAN: begin
            if (node_ff != ROOT_NODE && cur_word.count == '0) begin
               status_in = ST_ABSENT;
               state_in  = DONE;
            end else if (rem_ff == '0) begin
               node_in  = ROOT_NODE;
               rem_in   = REM_W'(KEY_BITS);
               state_in = D2_WAIT;
            end else if (alloc) begin
               status_in = ST_ABSENT;
               state_in  = DONE;
            end else begin
               node_in  = cur_child;
               rem_in   = rem_ff - REM_W'(1);
               state_in = D1_WAIT;
            end
         end
         D2_WAIT: state_in = D2_UPD;
         D2_UPD: begin
            word_wr = 1'b1;
            if (cur_word.count != '0) begin
               wr_word.count = cur_word.count - COUNT_W'(1);
            end
            if (rem_ff == '0) begin
               state_in = DONE;
            end else begin
               node_in  = cur_child;
               rem_in   = rem_ff - REM_W'(1);
               state_in = D2_WAIT;
            end
         end
         Q_WAIT: state_in = Q_NODE;
         Q_NODE: begin
            if (rem_ff == '0) begin
               state_in = DONE;
            end else begin
               same_in = cur_child;
               if (cur_opp != NULL_NODE) begin
                  node_in  = cur_opp;
                  state_in = Q_OWAIT;
               end else begin
                  node_in  = cur_child;
                  rem_in   = rem_ff - REM_W'(1);
                  state_in = Q_WAIT;
               end
            end
         end
         Q_OWAIT: state_in = Q_OPP;
         Q_OPP: begin
            rem_in = rem_ff - REM_W'(1);
            if (cur_word.count != '0) begin
               res_in[bit_idx] = 1'b1;
               state_in        = Q_NODE;
            end else begin
               node_in  = same_ff;
               state_in = Q_WAIT;
            end
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.xor_result = res_ff;
               rsp_data_in.status     = status_ff;
               state_in               = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase

      if (word_wr) begin
         if (node_ff == ROOT_NODE) begin
            root_in = wr_word;
         end else begin
            mem_we = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         fresh_ff     <= 1'b0;
         root_ff      <= '0;
         next_free_ff <= NFW'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         root_ff      <= root_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      rem_ff      <= rem_in;
      missing_ff  <= missing_in;
      same_ff     <= same_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      if (req_valid && req_ready) begin
         key_ff <= req_data.key;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[node_ff] <= wr_word;
      end
      rd_data_ff <= node_mem[node_ff];
   end

   a_alloc_in_pool: assert property (@(posedge clock) disable iff (reset)
      (state_ff == I2_UPD && rem_ff != '0 && alloc) |-> next_free_ff < NFW'(NODE_POOL))
      else $error("node allocated beyond pool");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready while request in progress");

   a_fail_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> rsp_data.xor_result == '0)
      else $error("nonzero result on failed request");

   a_fresh_not_root: assert property (@(posedge clock) disable iff (reset)
      fresh_ff |-> node_ff != ROOT_NODE)
      else $error("root marked as new node");

endmodule
